// ----- hdl/pskc_pkg.sv -----
// pskc_pkg: shared types, opcodes, status codes and constants of the
// position-specific k-mer counter
// no dependencies
package pskc_pkg;

  localparam int SymBits    = 2;
  localparam int CfgIdxBits = 2;
  localparam int CfgDatBits = 8;

  localparam int DefMaxLength = 16;
  localparam int DefMaxOrder  = 3;
  localparam int DefCountBits = 32;

  localparam logic [1:0] OrderRst  = 2'd2;
  localparam logic [4:0] LengthRst = 5'd16;
  localparam logic [7:0] CmapRst   = 8'd27;

  typedef enum logic [1:0] {
    OpInc   = 2'd0,
    OpDec   = 2'd1,
    OpRead  = 2'd2,
    OpClear = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatOk        = 2'd0,
    StatUnderflow = 2'd1,
    StatSaturated = 2'd2,
    StatIgnored   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgOrder  = 2'd0,
    CfgLength = 2'd1,
    CfgCmap   = 2'd2,
    CfgSpare  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FsmClear,
    FsmClearOut,
    FsmIdle,
    FsmResp
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] symbol;
    logic       seq_first;
    logic       use_complement;
    logic [3:0] read_position;
    logic [7:0] read_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] count_value;
    logic [3:0]  used_position;
    logic [7:0]  used_word;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxBits-1:0] index;
    logic [CfgDatBits-1:0] wdata;
  } cfg_item_t;

endpackage

// ----- hdl/pskc_intf.sv -----
// pskc_intf: valid/ready channel interfaces for items, results and
// configuration writes; depends on pskc_pkg
interface pskc_in_if import pskc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pskc_out_if import pskc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pskc_cfg_if import pskc_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/pskc_ram.sv -----
// pskc_ram: generic simple dual-port ram, one write and one registered read
// per cycle; no dependencies
module pskc_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/position_specific_kmer_counter.sv -----
// position_specific_kmer_counter: top level, sequence state, control and
// read-modify-write of the count table; depends on pskc_pkg, pskc_intf, pskc_ram
//
//   channel  dir  transfer when          payload
//   in_i     in   valid & ready          opcode, symbol, flags, read address
//   out_o    out  valid & ready          status, count, position, word
//   cfg_i    in   valid & ready (ready=1) register index, write data
//
// an item is handled in order: the transfer cycle issues the registered table
// read, then the FsmResp state updates the counter and loads the result register
// once that register is free; a result waits in its own register
// after reset, and after every clear opcode, a sweep zeroes the table one
// entry a cycle (MAX_LENGTH * 4**(MAX_ORDER+1) entries, 4096 by default)
// a stalled result only holds the block when the next result is due
module position_specific_kmer_counter import pskc_pkg::*; #(
  parameter int MAX_LENGTH = DefMaxLength,
  parameter int MAX_ORDER  = DefMaxOrder,
  parameter int COUNT_BITS = DefCountBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pskc_in_if.sink   in_i,
  pskc_out_if.source out_o,
  pskc_cfg_if.sink  cfg_i
);

  localparam int WordBits   = SymBits * (MAX_ORDER + 1);
  localparam int PosBits    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int PosCntBits = $clog2(MAX_LENGTH + 1);
  localparam int TabDepth   = MAX_LENGTH * (2 ** WordBits);
  localparam int AddrBits   = $clog2(TabDepth);

  // configuration registers
  logic [1:0] order_q;
  logic [4:0] length_q;
  logic [7:0] cmap_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q  <= OrderRst;
      length_q <= LengthRst;
      cmap_q   <= CmapRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CfgOrder:  order_q  <= cfg_i.data.wdata[1:0];
        CfgLength: length_q <= cfg_i.data.wdata[4:0];
        CfgCmap:   cmap_q   <= cfg_i.data.wdata;
        default:   ;
      endcase
    end
  end

  logic [7:0] len_eff;
  logic [2:0] ord_eff;

  always_comb begin
    if (length_q == 5'd0) begin
      len_eff = 8'd1;
    end else if (8'(length_q) > 8'(MAX_LENGTH)) begin
      len_eff = 8'(MAX_LENGTH);
    end else begin
      len_eff = 8'(length_q);
    end
    ord_eff = (3'(order_q) > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : 3'(order_q);
  end

  // state
  state_e state_q, state_d;
  logic [PosCntBits-1:0] npos_q, npos_d;
  logic [WordBits-1:0]   roll_q, roll_d;
  logic                  aband_q, aband_d;
  logic [AddrBits-1:0]   clr_cnt_q, clr_cnt_d;
  logic                  clr_emit_q, clr_emit_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_data_q, out_data_d;

  // latched item
  op_e                   op_q;
  logic                  ign_q;
  logic                  oor_q;
  logic [PosBits-1:0]    pos_q;
  logic [WordBits-1:0]   word_q;
  logic [3:0]            rpos_q;
  logic [WordBits-1:0]   rword_q;

  // item decode at transfer
  op_e                   in_op;
  logic                  cnt_op;
  logic                  first_eff;
  logic [PosCntBits-1:0] cur_pos;
  logic [WordBits-1:0]   cur_roll;
  logic                  cur_ab;
  logic                  ignored;
  logic [1:0]            sym_m;
  logic [WordBits-1:0]   mask;
  logic [WordBits-1:0]   word;
  logic [WordBits-1:0]   rword;
  logic                  oor;
  logic                  accept;

  assign in_op     = op_e'(in_i.data.opcode);
  assign cnt_op    = (in_op == OpInc) || (in_op == OpDec);
  assign first_eff = cnt_op && in_i.data.seq_first;
  assign cur_pos   = first_eff ? '0 : npos_q;
  assign cur_roll  = first_eff ? '0 : roll_q;
  assign cur_ab    = first_eff ? 1'b0 : aband_q;
  assign ignored   = cur_ab || (8'(cur_pos) >= len_eff);
  assign sym_m     = in_i.data.use_complement ?
                     cmap_q[{in_i.data.symbol, 1'b0} +: 2] : in_i.data.symbol;
  assign rword     = WordBits'(in_i.data.read_word);
  assign oor       = 8'(in_i.data.read_position) >= 8'(MAX_LENGTH);
  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == FsmIdle);

  // keep symbol i of the word while i <= min(position, order)
  always_comb begin
    for (int i = 0; i <= MAX_ORDER; i++) begin
      mask[i*SymBits +: SymBits] =
        {SymBits{(8'(i) <= 8'(cur_pos)) && (3'(i) <= ord_eff)}};
    end
  end

  assign word = WordBits'({cur_roll, sym_m}) & mask;

  // table ram
  logic                  ram_we;
  logic [AddrBits-1:0]   ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [AddrBits-1:0]   ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  assign ram_raddr = (in_op == OpRead) ?
                     AddrBits'({PosBits'(in_i.data.read_position), rword}) :
                     AddrBits'({PosBits'(cur_pos), word});

  pskc_ram #(
    .Width (COUNT_BITS),
    .Depth (TabDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_op;
      ign_q   <= ignored;
      oor_q   <= oor;
      pos_q   <= PosBits'(cur_pos);
      word_q  <= word;
      rpos_q  <= in_i.data.read_position;
      rword_q <= rword;
    end
  end

  logic slot_free;
  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    npos_d      = npos_q;
    roll_d      = roll_q;
    aband_d     = aband_q;
    clr_cnt_d   = clr_cnt_q;
    clr_emit_d  = clr_emit_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_q;
    ram_wdata   = '0;

    case (state_q)
      FsmClear: begin
        ram_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AddrBits'(TabDepth - 1)) begin
          clr_cnt_d = '0;
          state_d   = clr_emit_q ? FsmClearOut : FsmIdle;
        end
      end

      FsmClearOut: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d.status = StatOk;
          state_d     = FsmIdle;
        end
      end

      FsmIdle: begin
        if (accept && cnt_op) begin
          // position advances only once the counter is known
          npos_d  = cur_pos;
          aband_d = cur_ab;
          roll_d  = ignored ? cur_roll : word;
        end
        if (accept) begin
          state_d = FsmResp;
        end
      end

      FsmResp: begin
        if (op_q == OpClear) begin
          clr_emit_d = 1'b1;
          clr_cnt_d  = '0;
          state_d    = FsmClear;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = FsmIdle;
          ram_waddr   = AddrBits'({pos_q, word_q});
          out_data_d.used_position = 4'(pos_q);
          out_data_d.used_word     = 8'(word_q);
          if (op_q == OpRead) begin
            out_data_d.used_position = rpos_q;
            out_data_d.used_word     = 8'(rword_q);
            out_data_d.status        = oor_q ? StatIgnored : StatOk;
            out_data_d.count_value   = oor_q ? 32'd0 : 32'(ram_rdata);
          end else if (ign_q) begin
            out_data_d = '0;
            out_data_d.status = StatIgnored;
          end else if (op_q == OpInc) begin
            if (ram_rdata == '1) begin
              out_data_d.status      = StatSaturated;
              out_data_d.count_value = 32'(ram_rdata);
            end else begin
              ram_we                 = 1'b1;
              ram_wdata              = ram_rdata + 1'b1;
              out_data_d.status      = StatOk;
              out_data_d.count_value = 32'(ram_wdata);
            end
            npos_d = npos_q + 1'b1;
          end else begin
            if (ram_rdata == '0) begin
              // refused decrement drops the rest of the sequence
              aband_d                = 1'b1;
              out_data_d.status      = StatUnderflow;
              out_data_d.count_value = '0;
            end else begin
              ram_we                 = 1'b1;
              ram_wdata              = ram_rdata - 1'b1;
              out_data_d.status      = StatOk;
              out_data_d.count_value = 32'(ram_wdata);
              npos_d                 = npos_q + 1'b1;
            end
          end
        end
      end

      default: state_d = FsmIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmClear;
      npos_q      <= '0;
      roll_q      <= '0;
      aband_q     <= 1'b0;
      clr_cnt_q   <= '0;
      clr_emit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      npos_q      <= npos_d;
      roll_q      <= roll_d;
      aband_q     <= aband_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_emit_q  <= clr_emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ----- dv/position_specific_kmer_counter_tb.sv -----
// position_specific_kmer_counter_tb: self-checking bench for the k-mer count table
// a scoreboard class predicts every result; plain tasks drive items, config and stalls
// depends on pskc_pkg, pskc_intf and the position_specific_kmer_counter rtl
module position_specific_kmer_counter_tb import pskc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxLen      = DefMaxLength;
  localparam int MaxOrd      = DefMaxOrder;
  localparam int Words       = 1 << (SymBits * (MaxOrd + 1));
  localparam int LibSize     = 8;
  localparam int LibMaxLen   = 20;
  localparam int DrainCycles = 8;
  localparam int unsigned LimitCycles = 1_000_000;

  class kmer_count_scoreboard;
    bit [DefCountBits-1:0] counters [MaxLen*Words];
    bit [4:0]    next_pos;
    bit [7:0]    rolling;
    bit          abandoned;
    bit [1:0]    order;
    bit [4:0]    length;
    bit [7:0]    cmap;
    out_item_t   due_results[$];
    int unsigned touched[$];
    int          mismatches;

    function new();
      foreach (counters[i]) counters[i] = '0;
      next_pos   = '0;
      rolling    = '0;
      abandoned  = 1'b0;
      order      = OrderRst;
      length     = LengthRst;
      cmap       = CmapRst;
      mismatches = 0;
    endfunction

    function int unsigned eff_length();
      if (length == 0) return 1;
      return (length > MaxLen) ? MaxLen : length;
    endfunction

    function void write_reg(cfg_idx_e idx, bit [7:0] v);
      case (idx)
        CfgOrder:  order  = v[1:0];
        CfgLength: length = v[4:0];
        CfgCmap:   cmap   = v;
        default: ;
      endcase
    endfunction

    // note an accepted item, queue its result and return the status due
    function status_e take_item(in_item_t it);
      out_item_t   r;
      bit [1:0]    sym;
      bit [7:0]    word;
      int unsigned pos, ord, k, addr;
      r = '0;
      case (op_e'(it.opcode))
        OpClear: foreach (counters[i]) counters[i] = '0;
        OpRead: begin
          r.used_position = it.read_position;
          r.used_word     = it.read_word & 8'(Words - 1);
          if (it.read_position >= MaxLen) r.status = StatIgnored;
          else r.count_value = counters[int'(it.read_position) * Words + int'(r.used_word)];
        end
        default: begin
          if (it.seq_first) begin
            next_pos  = '0;
            rolling   = '0;
            abandoned = 1'b0;
          end
          if (abandoned || next_pos >= eff_length()) begin
            r.status = StatIgnored;
          end else begin
            sym  = it.use_complement ? cmap[2*it.symbol +: 2] : it.symbol;
            pos  = next_pos;
            ord  = (order > MaxOrd) ? MaxOrd : order;
            // short positions keep only the symbols seen so far
            k    = ((pos < ord) ? pos : ord) + 1;
            word = 8'(((int'(rolling) << SymBits) | sym) & ((1 << (SymBits * k)) - 1));
            rolling = word;
            addr = pos * Words + word;
            r.used_position = 4'(pos);
            r.used_word     = word;
            touched.push_back(addr);
            if (touched.size() > 32) void'(touched.pop_front());
            if (it.opcode == OpInc) begin
              if (counters[addr] == '1) r.status = StatSaturated;
              else counters[addr] += 1;
              r.count_value = counters[addr];
              next_pos += 1;
            end else if (counters[addr] == '0) begin
              abandoned = 1'b1;
              r.status  = StatUnderflow;
            end else begin
              counters[addr] -= 1;
              r.count_value = counters[addr];
              next_pos += 1;
            end
          end
        end
      endcase
      due_results.push_back(r);
      return status_e'(r.status);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing due: %p", got);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("count_value", want.count_value, got.count_value);
      check_field("used_position", want.used_position, got.used_position);
      check_field("used_word", want.used_word, got.used_word);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pskc_in_if  in_if ();
  pskc_out_if out_if ();
  pskc_cfg_if cfg_if ();

  position_specific_kmer_counter dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  kmer_count_scoreboard sb;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          rx_hold      = 0;
  int          counted_items = 0;
  int unsigned cycles = 0;

  // kept sequences for later replay
  bit [1:0] lib_sym  [LibSize][LibMaxLen];
  bit       lib_comp [LibSize][LibMaxLen];
  int       lib_len  [LibSize];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LimitCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked for
  initial begin
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_if.ready = 1'b0;
        rx_hold--;
      end else begin
        out_if.ready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  function automatic in_item_t rand_fields(op_e op);
    in_item_t it;
    it.opcode         = op;
    it.symbol         = 2'($urandom);
    it.seq_first      = 1'($urandom);
    it.use_complement = 1'($urandom);
    it.read_position  = 4'($urandom);
    it.read_word      = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t count_item(op_e op, bit [1:0] sym, bit first, bit comp);
    in_item_t it;
    it = rand_fields(op);
    it.symbol         = sym;
    it.seq_first      = first;
    it.use_complement = comp;
    return it;
  endfunction

  function automatic in_item_t read_item(bit [3:0] pos, bit [7:0] word);
    in_item_t it;
    it = rand_fields(OpRead);
    it.read_position = pos;
    it.read_word     = word;
    return it;
  endfunction

  // valid stays high after a transfer so back-to-back items need no gap
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data  = it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (sb.take_item(it) != StatIgnored) counted_items++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [7:0] v);
    @(negedge clk);
    cfg_if.valid      = 1'b1;
    cfg_if.data.index = idx;
    cfg_if.data.wdata = v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic reconfigure(bit [7:0] ord, bit [7:0] len, bit [7:0] cm, int tx, int rx);
    drain_results();
    repeat (DrainCycles) @(posedge clk);
    // a clear sweep may still be running
    while (!in_if.ready) @(posedge clk);
    write_reg(CfgOrder, ord);
    write_reg(CfgLength, len);
    write_reg(CfgCmap, cm);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
  endtask

  task automatic run_phase(int target);
    int start, kind, slot, len, a;
    op_e op;
    start = counted_items;
    while (counted_items - start < target) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        // fresh sequence counted upward and kept
        slot = $urandom_range(LibSize - 1);
        len  = $urandom_range(sb.eff_length() + 3, 1);
        lib_len[slot] = len;
        for (int i = 0; i < len; i++) begin
          lib_sym[slot][i]  = 2'($urandom);
          lib_comp[slot][i] = 1'($urandom);
          send_item(count_item(OpInc, lib_sym[slot][i], i == 0, lib_comp[slot][i]));
        end
      end else if (kind < 80) begin
        // replay of a kept sequence, mostly downward
        slot = $urandom_range(LibSize - 1);
        if (lib_len[slot] == 0) continue;
        op = ($urandom_range(3) == 0) ? OpInc : OpDec;
        for (int i = 0; i < lib_len[slot]; i++)
          send_item(count_item(op, lib_sym[slot][i], i == 0, lib_comp[slot][i]));
      end else if (kind < 90) begin
        repeat ($urandom_range(4, 1)) begin
          if (sb.touched.size() != 0 && $urandom_range(3) != 0) begin
            a = sb.touched[$urandom_range(sb.touched.size() - 1)];
            send_item(read_item(4'(a / Words), 8'(a % Words)));
          end else begin
            send_item(rand_fields(OpRead));
          end
        end
      end else if (kind < 99) begin
        // noise and broken sequences
        repeat ($urandom_range(6, 1)) send_item(rand_fields(op_e'($urandom_range(OpRead))));
      end else begin
        send_item(rand_fields(OpClear));
      end
    end
  endtask

  initial begin
    in_item_t it;
    sb = new();
    foreach (lib_len[i]) lib_len[i] = 0;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at reset settings
    send_item(read_item(4'd0, 8'd0));
    send_item(count_item(OpInc, 2'd3, 1'b1, 1'b0));
    send_item(count_item(OpInc, 2'd2, 1'b0, 1'b1));
    send_item(count_item(OpInc, 2'd1, 1'b0, 1'b0));
    send_item(count_item(OpInc, 2'd0, 1'b0, 1'b1));
    send_item(read_item(4'd3, 8'h17));
    send_item(count_item(OpInc, 2'd3, 1'b1, 1'b0));
    send_item(count_item(OpDec, 2'd3, 1'b1, 1'b0));
    send_item(count_item(OpDec, 2'd2, 1'b0, 1'b1));
    // never counted word: refused, rest of the sequence dropped
    send_item(count_item(OpDec, 2'd2, 1'b0, 1'b0));
    send_item(count_item(OpInc, 2'd1, 1'b0, 1'b0));
    send_item(count_item(OpDec, 2'd1, 1'b1, 1'b0));
    // first flag on a read must not restart the sequence
    it = read_item(4'd15, 8'hFF);
    it.seq_first = 1'b1;
    send_item(it);
    send_item(count_item(OpInc, 2'd2, 1'b0, 1'b1));
    send_item(rand_fields(OpClear));
    send_item(read_item(4'd0, 8'd3));
    send_item(count_item(OpInc, 2'd0, 1'b1, 1'b0));
    send_item(count_item(OpInc, 2'd3, 1'b0, 1'b1));
    send_item(count_item(OpInc, 2'd1, 1'b0, 1'b0));
    // clear keeps the sequence going
    send_item(rand_fields(OpClear));
    send_item(count_item(OpInc, 2'd2, 1'b0, 1'b0));
    send_item(read_item(4'd3, 8'h39));

    reconfigure(8'h00, 8'h10, 8'h1B, 0, 0);
    write_reg(CfgSpare, 8'hA5);
    run_phase(300);
    reconfigure(8'hFF, 8'h01, 8'h00, 51, 0);
    run_phase(60);
    reconfigure(8'h01, 8'hE0, 8'hFF, 0, 51);
    run_phase(60);
    reconfigure(8'h02, 8'hFF, 8'($urandom), 11, 11);
    run_phase(250);

    reconfigure(8'h03, 8'h10, 8'($urandom), 0, 0);
    run_phase(100);
    rx_hold = 600;
    run_phase(100);
    drain_results();
    run_phase(100);

    reconfigure(8'h01, 8'h07, 8'($urandom), 51, 0);
    run_phase(220);
    reconfigure(8'h00, 8'h11, 8'($urandom), 0, 51);
    run_phase(220);
    reconfigure(8'h03, 8'h09, 8'($urandom), 11, 11);
    run_phase(250);

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (sb.due_results.size() != 0) begin
      $error("%0d results never arrived", sb.due_results.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- position_specific_kmer_counter.f -----
hdl/pskc_pkg.sv
hdl/pskc_intf.sv
hdl/pskc_ram.sv
hdl/position_specific_kmer_counter.sv
dv/position_specific_kmer_counter_tb.sv
